@@ rtl/rpbd_pkg.sv @@
// Package for the run-length pattern bitmap decoder.
// Holds the frame limits, derived widths, the item codes and the item types.
// Depends on nothing; every rtl file imports it.
package rpbd_pkg;

    // Largest frame the bitmap store can hold.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;

    // Derived store geometry.
    localparam int STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = STRIDE_MAX * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int SW          = $clog2(STRIDE_MAX + 1);
    localparam int RW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Run counts and positions saturate at the top of a 16-bit count.
    localparam int          CNT_W   = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Generation tag kept with every store entry.
    localparam int EPOCH_W = 3;

    // Item modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Pattern characters.
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SET  = 8'h6F;
    localparam logic [7:0] CH_SKIP = 8'h62;
    localparam logic [7:0] CH_ROW  = 8'h24;
    localparam logic [7:0] CH_END  = 8'h21;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [12:0] read_address;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       terminated;
        logic       clipped;
    } t_result;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [7:0]         data;
    } t_entry;

endpackage

@@ rtl/rle_pattern_bitmap_decoder_unit.sv @@
// Top level of the run-length pattern bitmap decoder.
// Holds the decoder state, the bitmap store and its read-modify-write sequencer.
// Depends on rpbd_pkg.
//
// Usage: an item (mode, char_code, read_address) is taken when start is high
// and busy is low. Every item gives exactly one result on o_result, shown for
// one cycle with o_strobe high; the receiver cannot stall, so results are
// never held back. Registers frame_width and frame_height are written through
// the i_cfg_* channel, which is always ready.
// Timing: a start, a digit or any character that writes no cell answers in
// the next cycle, so such items may follow back to back, but for a start that
// begins the clearing sweep. A bitmap read goes through the store's registered
// read port and the S_RDOUT state before it answers. A run of set cells is
// written byte by byte, each byte a read then a write of the store, with busy
// high until the last byte, and the bytes touched are bounded by the row stride.
// Each store entry carries a 3-bit generation tag, so a start normally clears
// the bitmap at once; every eighth start, and reset, sweeps all 8192 entries,
// one a cycle, with busy held high throughout the sweep.
// Synchronous active-low reset returns the frame to 256 by 256 and starts
// with that clearing sweep.
module rle_pattern_bitmap_decoder_unit
    import rpbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_RDOUT = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // Registers.
    logic [2:0]         r_state, n_state;
    logic [8:0]         r_frame_width, r_frame_height;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_digit, n_digit;
    logic               r_seen, n_seen;
    logic               r_done, n_done;
    logic               r_clip, n_clip;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [WW-1:0]      r_cur, n_cur;
    logic [WW-1:0]      r_last, n_last;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic               r_rd_ok, n_rd_ok;
    logic [7:0]         r_rd_data, n_rd_data;
    logic               r_strobe, n_strobe;

    // Bitmap store.
    t_entry             mem [STORE_DEPTH];
    t_entry             r_mem_q;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    t_entry             mem_wdata;

    // Effective frame and helpers.
    logic [WW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;
    logic [SW-1:0]      stride;
    logic [RW+SW-1:0]   row_prod;
    logic [CNT_W-1:0]   run_n;
    logic [CNT_W:0]     col_end;
    logic [CNT_W:0]     row_step;
    logic [20:0]        digit_next;
    logic [3:0]         digit_in;
    logic [WW-3-1:0]    byte_idx;
    logic [WW:0]        byte_end;
    logic [WW:0]        last_ext;
    logic [3:0]         hi_bit;
    logic [7:0]         cell_mask;
    logic [7:0]         old_byte;
    logic [ADDR_W-1:0]  cur_addr;
    logic               is_digit;

    // Register values out of range act as the nearest limit.
    always_comb begin
        if (r_frame_width == 9'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height == 9'd0) begin
            eff_h = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_frame_height);
        end
    end

    // Row stride and the byte address of the current row.
    assign stride   = SW'(((WW+1)'(eff_w) + (WW+1)'(7)) >> 3);
    assign row_prod = (RW+SW)'(r_row[RW-1:0]) * (RW+SW)'(stride);

    // Run count and the positions it leads to.
    assign is_digit   = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign digit_in   = 4'(i_item.char_code - CH_ZERO);
    assign digit_next = (21'(r_digit) << 3) + (21'(r_digit) << 1) + 21'(digit_in);
    assign run_n      = r_seen ? r_digit : CNT_W'(1);
    assign col_end    = (CNT_W+1)'(r_col) + (CNT_W+1)'(run_n);
    assign row_step   = (CNT_W+1)'(r_row)
                      + ((run_n != '0) ? (CNT_W+1)'(run_n) : (CNT_W+1)'(1));

    // Byte being written by the run sequencer and the cells it gets.
    assign byte_idx  = r_cur[WW-1:3];
    assign byte_end  = (WW+1)'({r_cur[WW-1:3], 3'b000}) + (WW+1)'(8);
    assign last_ext  = (WW+1)'(r_last);
    assign hi_bit    = (byte_end <= last_ext) ? 4'd8 : {1'b0, r_last[2:0]};
    assign cell_mask = (8'hFF >> r_cur[2:0]) & ~(8'hFF >> hi_bit);
    assign cur_addr  = r_row_base + ADDR_W'(byte_idx);
    assign old_byte  = (r_mem_q.tag == r_epoch) ? r_mem_q.data : 8'h00;

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_digit    = r_digit;
        n_seen     = r_seen;
        n_done     = r_done;
        n_clip     = r_clip;
        n_epoch    = r_epoch;
        n_clr_addr = r_clr_addr;
        n_cur      = r_cur;
        n_last     = r_last;
        n_row_base = r_row_base;
        n_rd_ok    = r_rd_ok;
        n_rd_data  = r_rd_data;
        n_strobe   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = '{tag: r_epoch, data: old_byte | cell_mask};
        mem_raddr  = cur_addr;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the store, tagging every entry with the current generation.
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '{tag: r_epoch, data: 8'h00};
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                mem_raddr = ADDR_W'(i_item.read_address);
                if (start) begin
                    n_rd_data = 8'h00;
                    n_strobe  = 1'b1;
                    unique case (i_item.mode)
                        MODE_START: begin
                            n_col      = '0;
                            n_row      = '0;
                            n_digit    = '0;
                            n_seen     = 1'b0;
                            n_done     = 1'b0;
                            n_clip     = 1'b0;
                            n_epoch    = r_epoch + EPOCH_W'(1);
                            n_clr_addr = '0;
                            // A wrapped generation would revive stale entries.
                            if (n_epoch == '0) begin
                                n_state = S_CLEAR;
                            end
                        end
                        MODE_CHAR: begin
                            if (!r_done && i_item.char_code != CH_LF
                                    && i_item.char_code != CH_CR) begin
                                if (is_digit) begin
                                    n_digit = (digit_next > 21'(CNT_MAX))
                                            ? CNT_MAX : CNT_W'(digit_next);
                                    n_seen  = 1'b1;
                                end else begin
                                    n_digit = '0;
                                    n_seen  = 1'b0;
                                    case (i_item.char_code)
                                        CH_SET: begin
                                            if (run_n != '0) begin
                                                n_col = col_end[CNT_W] ? CNT_MAX
                                                      : col_end[CNT_W-1:0];
                                                if (r_row >= CNT_W'(eff_h)) begin
                                                    n_clip = 1'b1;
                                                end else begin
                                                    if (col_end > (CNT_W+1)'(eff_w)) begin
                                                        n_clip = 1'b1;
                                                        n_last = eff_w;
                                                    end else begin
                                                        n_last = WW'(col_end);
                                                    end
                                                    // Cells inside the row go to the store.
                                                    if (r_col < CNT_W'(eff_w)) begin
                                                        n_cur      = WW'(r_col);
                                                        n_row_base = ADDR_W'(row_prod);
                                                        n_strobe   = 1'b0;
                                                        n_state    = S_RD;
                                                    end
                                                end
                                            end
                                        end
                                        CH_SKIP: begin
                                            n_col = col_end[CNT_W] ? CNT_MAX
                                                  : col_end[CNT_W-1:0];
                                        end
                                        CH_ROW: begin
                                            n_row = row_step[CNT_W] ? CNT_MAX
                                                  : row_step[CNT_W-1:0];
                                            n_col = '0;
                                        end
                                        CH_END: begin
                                            n_done = 1'b1;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                            end
                        end
                        MODE_READ: begin
                            n_rd_ok  = 32'(i_item.read_address) < STORE_DEPTH;
                            n_strobe = 1'b0;
                            n_state  = S_RDOUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_WR;
            end

            S_WR: begin
                // Merge the run's cells into the byte just read.
                mem_we = 1'b1;
                n_cur  = WW'(byte_end);
                if (byte_end >= last_ext) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end

            S_RDOUT: begin
                n_rd_data = r_rd_ok ? old_byte : 8'h00;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
            r_col          <= '0;
            r_row          <= '0;
            r_digit        <= '0;
            r_seen         <= 1'b0;
            r_done         <= 1'b0;
            r_clip         <= 1'b0;
            r_epoch        <= '0;
            r_clr_addr     <= '0;
            r_strobe       <= 1'b0;
            r_rd_data      <= 8'h00;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_digit    <= n_digit;
            r_seen     <= n_seen;
            r_done     <= n_done;
            r_clip     <= n_clip;
            r_epoch    <= n_epoch;
            r_clr_addr <= n_clr_addr;
            r_strobe   <= n_strobe;
            r_rd_data  <= n_rd_data;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_frame_width <= i_cfg_data;
                end else begin
                    r_frame_height <= i_cfg_data;
                end
            end
        end
    end

    // Run sequencer payload.
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_last     <= n_last;
        r_row_base <= n_row_base;
        r_rd_ok    <= n_rd_ok;
    end

    // Store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    // Outputs.
    assign busy                = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_strobe            = r_strobe;
    assign o_result.read_data  = r_rd_data;
    assign o_result.terminated = r_done;
    assign o_result.clipped    = r_clip;

`ifndef SYNTHESIS
    // A bitmap read answers after the registered store read and the S_RDOUT state.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.mode == MODE_READ) |=> !o_strobe ##1 o_strobe)
        else $error("bitmap read result not two cycles after acceptance");

    // The terminated flag only drops because of a start item.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_result.terminated) && $past(i_rst_n))
            |-> $past(start && !busy && i_item.mode == MODE_START))
        else $error("terminated flag cleared without a start item");

    // Non-zero read data only comes out of the store read state.
    a_data_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.read_data != 8'h00) |-> $past(r_state == S_RDOUT))
        else $error("non-zero read data outside a bitmap read");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the run-length pattern bitmap decoder.
// Drives start/busy items and frame register writes, and checks every result against a
// decoder model kept here. Depends on rpbd_pkg and rle_pattern_bitmap_decoder_unit.
module tb_top;
    import rpbd_pkg::*;

    // Mode left unused by the block, and a character with no meaning in a pattern.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] CH_OTHER   = 8'h78;
    localparam int         RUN_LIMIT  = 3_000_000;
    localparam int         PHASES     = 5;
    localparam int         PHASE_ITEMS = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_item       i_item      = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_WIDTH;
    logic [8:0]  i_cfg_data  = '0;

    rle_pattern_bitmap_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the decoder: bitmap, positions, run count, flags and frame registers.
    logic [7:0]  bmp [STORE_DEPTH];
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    logic [15:0] run_digits;
    logic        run_given;
    logic        ended;
    logic        clipped_any;
    logic [8:0]  reg_width  = 9'd256;
    logic [8:0]  reg_height = 9'd256;

    // Results the decoder still owes, oldest first.
    t_result decoded_q [$];

    int idle_pct     = 0;
    int items_sent   = 0;
    int reads_sent   = 0;
    int patterns     = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int cycle_count  = 0;

    function automatic logic [15:0] sat16(input int unsigned v);
        return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // A register value of 0 acts as 1, and one above the store's limit acts as the limit.
    function automatic int unsigned clamp_dim(input logic [8:0] v, input int unsigned top);
        if (v == 9'd0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic void clear_pattern();
        foreach (bmp[i]) bmp[i] = 8'h00;
        col_pos     = '0;
        row_pos     = '0;
        run_digits  = '0;
        run_given   = 1'b0;
        ended       = 1'b0;
        clipped_any = 1'b0;
    endfunction

    // Set a run of cells on the current row; anything beyond the frame is dropped and flagged.
    function automatic void paint_run(input int unsigned n);
        int unsigned w;
        int unsigned h;
        int unsigned stride;
        int unsigned stop;
        int unsigned addr;
        w      = clamp_dim(reg_width, MAX_WIDTH);
        h      = clamp_dim(reg_height, MAX_HEIGHT);
        stride = (w + 7) / 8;
        stop   = col_pos + n;
        if (n == 0) return;
        if (row_pos >= h) begin
            clipped_any = 1'b1;
        end else begin
            for (int unsigned c = col_pos; c < stop && c < w; c++) begin
                addr = row_pos * stride + c / 8;
                if (addr < STORE_DEPTH) bmp[addr] = bmp[addr] | (8'h80 >> (c % 8));
            end
            if (stop > w) clipped_any = 1'b1;
        end
        col_pos = sat16(col_pos + n);
    endfunction

    function automatic void feed_char(input logic [7:0] ch);
        int unsigned run;
        int unsigned v;
        if (ended || ch == CH_LF || ch == CH_CR) return;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            v          = run_digits * 10 + (ch - CH_ZERO);
            run_digits = sat16(v);
            run_given  = 1'b1;
            return;
        end
        run = run_given ? run_digits : 1;
        case (ch)
            CH_SET:  paint_run(run);
            CH_SKIP: col_pos = sat16(col_pos + run);
            CH_ROW: begin
                row_pos = sat16(row_pos + ((run != 0) ? run : 1));
                col_pos = '0;
            end
            CH_END:  ended = 1'b1;
            default: ;
        endcase
        run_digits = '0;
        run_given  = 1'b0;
    endfunction

    // Expected result of one item, advancing the shadow state.
    function automatic t_result decode_item(input t_item it);
        t_result r;
        r = '0;
        case (it.mode)
            MODE_START: clear_pattern();
            MODE_CHAR:  feed_char(it.char_code);
            MODE_READ: begin
                if (it.read_address < STORE_DEPTH) r.read_data = bmp[it.read_address];
            end
            default: ;
        endcase
        r.terminated = ended;
        r.clipped    = clipped_any;
        return r;
    endfunction

    function automatic t_item mk_item(input logic [1:0] m, input logic [7:0] c,
                                      input logic [12:0] a);
        t_item it;
        it.mode         = m;
        it.char_code    = c;
        it.read_address = a;
        return it;
    endfunction

    // Present one item, possibly after an idle gap, and hold it until it is taken.
    task automatic offer(input t_item it, input bit typed, input t_result given);
        t_result r;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        r = decode_item(it);
        decoded_q.push_back(typed ? given : r);
        items_sent++;
        if (it.mode == MODE_READ) reads_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        offer(mk_item(MODE_CHAR, ch, 13'($urandom_range(8191))), 1'b0, '0);
    endtask

    // Stop sending until every owed result has come and the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (decoded_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_width = w;
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_height = h;
        i_cfg_valid <= 1'b0;
    endtask

    // A run count: none, zero, in the frame, past the frame, or large, up to far past saturation.
    function automatic int pick_run(input int unsigned span);
        case ($urandom_range(15))
            0:       return 0;
            1:       return $urandom_range(60000, 999999);
            2:       return span + $urandom_range(1, 40);
            3, 4, 5: return -1;
            default: return $urandom_range(1, span);
        endcase
    endfunction

    // Send a run count as digits, with the odd line break inside it, then its tag.
    task automatic emit_run(input int n, input logic [7:0] tag);
        string digits;
        if (n >= 0) begin
            digits = $sformatf("%0d", n);
            for (int i = 0; i < digits.len(); i++) begin
                if (i > 0 && $urandom_range(7) == 0) send_char($urandom_range(1) ? CH_LF : CH_CR);
                send_char(digits[i]);
            end
        end
        send_char(tag);
    endtask

    // One pattern: a start, a body of runs with some noise, mostly a terminator, then reads.
    task automatic play_pattern();
        int unsigned w;
        int unsigned h;
        int unsigned stride;
        int unsigned addr;
        w      = clamp_dim(reg_width, MAX_WIDTH);
        h      = clamp_dim(reg_height, MAX_HEIGHT);
        stride = (w + 7) / 8;
        offer(mk_item(MODE_START, 8'($urandom_range(255)), 13'($urandom_range(8191))),
              1'b0, '0);
        patterns++;
        repeat ($urandom_range(4, 24)) begin
            case ($urandom_range(19))
                0: begin
                    if ($urandom_range(1))
                        offer(mk_item(MODE_SPARE, 8'($urandom_range(255)),
                                      13'($urandom_range(8191))), 1'b0, '0);
                    else
                        send_char(8'($urandom_range(255)));
                end
                1, 2, 3: emit_run(pick_run(2), CH_ROW);
                4, 5, 6: emit_run(pick_run(w), CH_SKIP);
                7:       emit_run(pick_run(w), CH_SET);
                default: emit_run(pick_run((w < 40) ? w : 40), CH_SET);
            endcase
        end
        if ($urandom_range(9) != 0) begin
            send_char(CH_END);
            if ($urandom_range(3) == 0) send_char(CH_SET);
        end
        repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(4) == 0)
                addr = $urandom_range(8191);
            else
                addr = $urandom_range(0, (h < 13) ? h - 1 : 12) * stride
                       + $urandom_range(0, stride - 1);
            offer(mk_item(MODE_READ, 8'($urandom_range(255)), 13'(addr)), 1'b0, '0);
        end
    endtask

    // Directed items; a typed expectation stands where it is plain, otherwise the model decides.
    typedef struct {
        t_item   it;
        bit      typed;
        t_result given;
    } t_step;

    t_step steps [$];

    function automatic void add_step(input logic [1:0] m, input logic [7:0] c,
                                     input logic [12:0] a, input bit typed,
                                     input logic [7:0] rd, input bit term, input bit clp);
        t_step s;
        s.it               = mk_item(m, c, a);
        s.typed            = typed;
        s.given.read_data  = rd;
        s.given.terminated = term;
        s.given.clipped    = clp;
        steps.push_back(s);
    endfunction

    // Compare each result with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (decoded_q.size() == 0) begin
                mismatches++;
                $error("result with none owed: %p", o_result);
            end else begin
                want = decoded_q.pop_front();
                results_seen++;
                if (o_result.read_data !== want.read_data) begin
                    mismatches++;
                    $error("read_data: expected %02h, got %02h",
                           want.read_data, o_result.read_data);
                end
                if (o_result.terminated !== want.terminated) begin
                    mismatches++;
                    $error("terminated: expected %0b, got %0b",
                           want.terminated, o_result.terminated);
                end
                if (o_result.clipped !== want.clipped) begin
                    mismatches++;
                    $error("clipped: expected %0b, got %0b", want.clipped, o_result.clipped);
                end
            end
        end
    end

    // Give up when the run takes far longer than any correct run could.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [8:0] w;
        logic [8:0] h;
        clear_pattern();

        // Reset is held, then released.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state, the unused mode, a lone cell, runs, zero counts, line breaks
        // inside a count, a full row, a dropped count, clipping and termination.
        add_step(MODE_READ,  8'h00, 13'd0,     1, 8'h00, 0, 0);
        add_step(MODE_SPARE, 8'hFF, 13'h1FFF,  1, 8'h00, 0, 0);
        add_step(MODE_START, 8'hFF, 13'h1FFF,  1, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_READ,  8'h00, 13'd0,     1, 8'h80, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd1, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd2, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO, 13'd0,   0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_READ,  8'h00, 13'd1,     0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO, 13'd0,   0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ROW, 13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd2, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_LF,  13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd5, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_CR,  13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd6, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    0, 8'h00, 0, 0);
        add_step(MODE_READ,  8'h00, 13'd63,    1, 8'hFF, 0, 0);
        add_step(MODE_CHAR,  CH_ZERO + 8'd5, 13'd0, 0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_OTHER, 13'd0,  0, 8'h00, 0, 0);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    1, 8'h00, 0, 1);
        add_step(MODE_CHAR,  CH_END, 13'd0,    1, 8'h00, 1, 1);
        add_step(MODE_CHAR,  CH_SET, 13'd0,    1, 8'h00, 1, 1);
        add_step(MODE_READ,  8'h00, 13'h1FFF,  1, 8'h00, 1, 1);
        add_step(MODE_START, 8'h00, 13'd0,     1, 8'h00, 0, 0);
        foreach (steps[i]) offer(steps[i].it, steps[i].typed, steps[i].given);

        // Random patterns under several frame settings and amounts of sender idling.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                1:       begin w = 9'd1;   h = 9'd1;   idle_pct = 62; end
                2:       begin w = 9'($urandom_range(9, 64)); h = 9'($urandom_range(2, 40));
                               idle_pct = 37; end
                3:       begin w = 9'd511; h = 9'd0;   idle_pct = 0;  end
                4:       begin w = 9'($urandom_range(511)); h = 9'($urandom_range(511));
                               idle_pct = 62; end
                default: begin w = 9'd256; h = 9'd256; idle_pct = 0;  end
            endcase
            set_frame(w, h);
            while (items_sent < steps.size() + (p + 1) * PHASE_ITEMS) begin
                play_pattern();
                if ($urandom_range(7) == 0) settle();
            end
        end

        settle();
        repeat (100) @(posedge i_clk);
        $display("Decoded %0d patterns in %0d items, %0d of them bitmap reads, over %0d frame",
                 patterns, items_sent, reads_sent, PHASES);
        $display("settings from 1x1 to 256x256 with clamped values; %0d results compared.",
                 results_seen);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ rle_pattern_bitmap_decoder_unit.f @@
rtl/rpbd_pkg.sv
rtl/rle_pattern_bitmap_decoder_unit.sv
sim/tb_top.sv
